FILE: rtl/dsa_signature_verifier_unit_assert.svh
// ----------------------------------------------------------------------------
// dsa verifier assertion macros
// shared concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef DSA_SIGNATURE_VERIFIER_UNIT_ASSERT_SVH
`define DSA_SIGNATURE_VERIFIER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// implication checked on every edge outside reset
`define DSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define DSV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DSV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DSV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsa verifier package
// widths and shared types
// ----------------------------------------------------------------------------
package dsv_pkg;
	localparam int MOD_BITS = 32;
	localparam int CNT_W = $clog2(MOD_BITS + 1);
	localparam int DIG_W = 64;
	localparam int DCNT_W = $clog2(DIG_W + 1);

	typedef logic [MOD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		CFG_P = 2'd0,
		CFG_Q = 2'd1,
		CFG_G = 2'd2,
		CFG_Y = 2'd3
	} cfg_idx_t;

	// modular multiplier handshake
	typedef struct packed {
		logic start;
		word_t a;
		word_t b;
		word_t m;
	} mm_req_t;

	typedef struct packed {
		logic done;
		word_t prod;
	} mm_rsp_t;
endpackage

FILE: rtl/dsv_modmul.sv
// ----------------------------------------------------------------------------
// dsa verifier modular multiplier
// bit-serial shift and add, one multiplier bit per cycle, a,b < m
// ----------------------------------------------------------------------------
module dsv_modmul import dsv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);
	word_t a_q, b_q, m_q, acc_q;
	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MOD_BITS:0] sa, sd;
	word_t acc_n, a_n;

	always_comb begin
		sa = {1'b0, acc_q} + {1'b0, a_q};
		acc_n = (sa >= {1'b0, m_q}) ? word_t'(sa - {1'b0, m_q}) : sa[MOD_BITS-1:0];
		if (!b_q[0]) acc_n = acc_q;
		sd = {a_q, 1'b0};
		a_n = (sd >= {1'b0, m_q}) ? word_t'(sd - {1'b0, m_q}) : sd[MOD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_n;
			a_q <= a_n;
			b_q <= b_q >> 1;
		end
	end
	assign rsp = '{done: done_q, prod: acc_q};
endmodule

FILE: rtl/dsv_divider.sv
// ----------------------------------------------------------------------------
// dsa verifier restoring divider
// n / d one quotient bit per cycle; n of DIG_W bits (MOD_BITS unless wide), d of MOD_BITS
// ----------------------------------------------------------------------------
module dsv_divider import dsv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              wide,
	input  logic [DIG_W-1:0]  num,
	input  word_t             den,
	output logic              done,
	output logic [DIG_W-1:0]  quo,
	output word_t             rem
);
	logic [DIG_W-1:0] n_q;
	word_t d_q, r_q;
	logic busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [MOD_BITS:0] trial;

	assign trial = {r_q, n_q[DIG_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= wide ? DCNT_W'(DIG_W) : DCNT_W'(MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= wide ? num : {num[MOD_BITS-1:0], {(DIG_W-MOD_BITS){1'b0}}};
			d_q <= den;
			r_q <= '0;
			quo <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (trial >= {1'b0, d_q}) begin
				r_q <= word_t'(trial - {1'b0, d_q});
				quo <= {quo[DIG_W-2:0], 1'b1};
			end else begin
				r_q <= trial[MOD_BITS-1:0];
				quo <= {quo[DIG_W-2:0], 1'b0};
			end
		end
	end
	assign rem = r_q;
endmodule

FILE: rtl/dsa_signature_verifier_unit.sv
// ----------------------------------------------------------------------------
// dsa signature verifier
// checks one signature (digest, r, s) against configured p, q, g, y
// ----------------------------------------------------------------------------
// usage:
//  - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes p, q,
//    g, y by index 0..3; write only while the block is idle
//  - input channel in_valid/in_stall carries digest, sig_r, sig_s; one
//    transaction in flight, in_stall stays high until its result is taken
//  - output channel out_valid/out_stall carries valid_res, no_inverse;
//    the result register holds while out_stall is high
//  - latency is data dependent: it grows with the number of euclid steps
//    and with the one bits of the two 32-bit exponents, each of which adds
//    a modular product; the 64-bit digest reduction takes longer than a
//    32-bit division; p or q below two gives the result in the cycle
//    after the transaction is taken
//  - one shared bit-serial multiplier and one bit-serial divider set
//    the rate; the next transaction is taken the cycle after a result leaves
//  - reset clears p, q, g, y to zero and drops any transaction
// ----------------------------------------------------------------------------
`include "dsa_signature_verifier_unit_assert.svh"
module dsa_signature_verifier_unit import dsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] digest,
	input  logic [31:0] sig_r,
	input  logic [31:0] sig_s,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic        no_inverse
);
	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_SRED  = 14'b00000000000010,
		ST_EDIV  = 14'b00000000000100,
		ST_EMUL  = 14'b00000000001000,
		ST_ZRED  = 14'b00000000010000,
		ST_RRED  = 14'b00000000100000,
		ST_U1    = 14'b00000001000000,
		ST_U2    = 14'b00000010000000,
		ST_BRED  = 14'b00000100000000,
		ST_PACC  = 14'b00001000000000,
		ST_PSQ   = 14'b00010000000000,
		ST_VMUL  = 14'b00100000000000,
		ST_VRED  = 14'b01000000000000,
		ST_OUT   = 14'b10000000000000
	} state_t;

	state_t st_q;
	word_t p_q, q_q, g_q, y_q;
	logic [DIG_W-1:0] z_q;
	word_t r_q;
	// euclid state
	word_t r0_q, r1_q, t0_q, t1_q, qt_q;
	// exponent state
	word_t w_q, zr_q, u1_q, u2_q, base_q, e_q, acc_q, v1_q;
	logic pass_q;   // 0: g^u1, 1: y^u2
	logic wait_q;
	logic res_q, ninv_q;

	mm_req_t mreq;
	mm_rsp_t mrsp;
	logic dstart, dwide, ddone;
	logic [DIG_W-1:0] dnum, dquo;
	word_t dden, drem;

	dsv_modmul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	dsv_divider u_div (.clk(clk), .arst_n(arst_n), .start(dstart), .wide(dwide),
		.num(dnum), .den(dden), .done(ddone), .quo(dquo), .rem(drem));

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign valid_res = res_q;
	assign no_inverse = ninv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			q_q <= '0;
			g_q <= '0;
			y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_P: p_q <= word_t'(cfg_data);
				CFG_Q: q_q <= word_t'(cfg_data);
				CFG_G: g_q <= word_t'(cfg_data);
				CFG_Y: y_q <= word_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// t0 - t1*qt mod q as one subtraction once the product is back
	word_t tn;
	always_comb begin
		tn = (t0_q >= mrsp.prod) ? word_t'(t0_q - mrsp.prod)
			: word_t'(t0_q + (q_q - mrsp.prod));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			wait_q <= 1'b0;
			mreq.start <= 1'b0;
			dstart <= 1'b0;
			pass_q <= 1'b0;
		end else begin
			mreq.start <= 1'b0;
			dstart <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (p_q < 2 || q_q < 2) begin
							ninv_q <= 1'b1;
							res_q <= 1'b0;
							st_q <= ST_OUT;
						end else begin
							dstart <= 1'b1;
							dwide <= 1'b0;
							dnum <= DIG_W'(sig_s);
							dden <= q_q;
							st_q <= ST_SRED;
						end
						z_q <= digest;
						r_q <= word_t'(sig_r);
					end
				end
				ST_SRED: if (ddone) begin
					r0_q <= q_q;
					r1_q <= drem;
					t0_q <= '0;
					t1_q <= word_t'(1);
					st_q <= ST_EDIV;
					wait_q <= 1'b0;
				end
				ST_EDIV: begin
					if (!wait_q) begin
						if (r1_q == '0) begin
							if (r0_q != word_t'(1)) begin
								ninv_q <= 1'b1;
								res_q <= 1'b0;
								st_q <= ST_OUT;
							end else begin
								w_q <= t0_q;
								dstart <= 1'b1;
								dwide <= 1'b1;
								dnum <= z_q;
								dden <= q_q;
								st_q <= ST_ZRED;
							end
						end else begin
							dstart <= 1'b1;
							dwide <= 1'b0;
							dnum <= DIG_W'(r0_q);
							dden <= r1_q;
							wait_q <= 1'b1;
						end
					end else if (ddone) begin
						qt_q <= dquo[MOD_BITS-1:0];
						r0_q <= r1_q;
						r1_q <= drem;
						// qt reaches q only on the first step with r1 == 1;
						// reduce it so the multiplier operand stays below q
						mreq.a <= (dquo[MOD_BITS-1:0] >= q_q)
							? word_t'(dquo[MOD_BITS-1:0] - q_q) : dquo[MOD_BITS-1:0];
						mreq.b <= t1_q;
						mreq.m <= q_q;
						mreq.start <= 1'b1;
						st_q <= ST_EMUL;
					end
				end
				ST_EMUL: if (mrsp.done) begin
					t0_q <= t1_q;
					t1_q <= tn;
					wait_q <= 1'b0;
					st_q <= ST_EDIV;
				end
				ST_ZRED: if (ddone) begin
					zr_q <= drem;
					dstart <= 1'b1;
					dwide <= 1'b0;
					dnum <= DIG_W'(r_q);
					dden <= q_q;
					st_q <= ST_RRED;
				end
				ST_RRED: if (ddone) begin
					mreq.a <= zr_q;
					mreq.b <= w_q;
					mreq.m <= q_q;
					mreq.start <= 1'b1;
					u2_q <= drem;
					st_q <= ST_U1;
				end
				ST_U1: if (mrsp.done) begin
					u1_q <= mrsp.prod;
					mreq.a <= u2_q;
					mreq.b <= w_q;
					mreq.m <= q_q;
					mreq.start <= 1'b1;
					st_q <= ST_U2;
				end
				ST_U2: if (mrsp.done) begin
					u2_q <= mrsp.prod;
					pass_q <= 1'b0;
					dstart <= 1'b1;
					dwide <= 1'b0;
					dnum <= DIG_W'(g_q);
					dden <= p_q;
					st_q <= ST_BRED;
				end
				ST_BRED: if (ddone) begin
					base_q <= drem;
					e_q <= pass_q ? u2_q : u1_q;
					acc_q <= word_t'(1);
					wait_q <= 1'b0;
					st_q <= ST_PACC;
				end
				ST_PACC: begin
					if (!wait_q) begin
						if (e_q == '0) begin
							if (!pass_q) begin
								v1_q <= acc_q;
								pass_q <= 1'b1;
								dstart <= 1'b1;
								dwide <= 1'b0;
								dnum <= DIG_W'(y_q);
								dden <= p_q;
								st_q <= ST_BRED;
							end else begin
								mreq.a <= v1_q;
								mreq.b <= acc_q;
								mreq.m <= p_q;
								mreq.start <= 1'b1;
								st_q <= ST_VMUL;
							end
						end else if (e_q[0]) begin
							mreq.a <= acc_q;
							mreq.b <= base_q;
							mreq.m <= p_q;
							mreq.start <= 1'b1;
							wait_q <= 1'b1;
						end else begin
							st_q <= ST_PSQ;
							mreq.a <= base_q;
							mreq.b <= base_q;
							mreq.m <= p_q;
							mreq.start <= 1'b1;
						end
					end else if (mrsp.done) begin
						acc_q <= mrsp.prod;
						wait_q <= 1'b0;
						mreq.a <= base_q;
						mreq.b <= base_q;
						mreq.m <= p_q;
						mreq.start <= 1'b1;
						st_q <= ST_PSQ;
					end
				end
				ST_PSQ: if (mrsp.done) begin
					base_q <= mrsp.prod;
					e_q <= e_q >> 1;
					st_q <= ST_PACC;
				end
				ST_VMUL: if (mrsp.done) begin
					dstart <= 1'b1;
					dwide <= 1'b0;
					dnum <= DIG_W'(mrsp.prod);
					dden <= q_q;
					st_q <= ST_VRED;
				end
				ST_VRED: if (ddone) begin
					res_q <= (drem == r_q);
					ninv_q <= 1'b0;
					st_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// acc = 1 mod p with p >= 2 is 1, so the initial accumulator is plain one
	`DSV_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(st_q))
	`DSV_ASSERT_IMP(a_flag_excl, clk, arst_n, out_valid, !(valid_res && no_inverse))
	`DSV_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(valid_res) && $stable(no_inverse))
	`DSV_ASSERT_IMP(a_one_unit, clk, arst_n, mreq.start, !dstart)
endmodule

FILE: test/dsa_signature_verifier_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsa signature verifier testbench
// drives digests and signature pairs through the verifier under several
// domain parameter sets, predicts each verdict with an independent
// integer model and compares every result transaction field by field
// ----------------------------------------------------------------------------
module dsa_signature_verifier_unit_tb import dsv_pkg::*;;

	localparam int LIMIT_CYCLES = 8000000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		bit valid_res;
		bit no_inverse;
	} verdict_t;

	// dut signals
	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] digest;
	logic [31:0] sig_r;
	logic [31:0] sig_s;
	logic        out_valid;
	logic        out_stall;
	logic        valid_res;
	logic        no_inverse;

	// shadow copy of the domain parameters
	logic [31:0] p_reg, q_reg, g_reg, y_reg;
	// private key of the current parameter set
	longint unsigned priv_x;

	verdict_t verdict_q[$];
	int errors;
	longint cycles;
	bit no_idle;
	int hold_req;

	dsa_signature_verifier_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.digest     (digest),
		.sig_r      (sig_r),
		.sig_s      (sig_s),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.valid_res  (valid_res),
		.no_inverse (no_inverse)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// modular arithmetic for the verdict predictor
	// ------------------------------------------------------------------
	// operands stay below 2^32 so the 64-bit product is exact
	function automatic longint unsigned mul_m(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return ((a % m) * (b % m)) % m;
	endfunction

	function automatic longint unsigned pow_m(longint unsigned base, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		base = base % m;
		while (e != 0) begin
			if (e[0])
				acc = mul_m(acc, base, m);
			base = mul_m(base, base, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// extended euclid, coefficients kept mod m; ok is cleared if gcd != 1
	function automatic longint unsigned inv_m(longint unsigned a, longint unsigned m,
			output bit ok);
		longint unsigned r0, r1, t0, t1, qt, rn, tn, prod;
		r0 = m;
		r1 = a % m;
		t0 = 0;
		t1 = 1 % m;
		while (r1 != 0) begin
			qt = r0 / r1;
			rn = r0 - qt * r1;
			prod = mul_m(qt, t1, m);
			tn = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		ok = (r0 == 1);
		return t0;
	endfunction

	function automatic verdict_t dsa_verdict(logic [63:0] z, logic [31:0] r, logic [31:0] s);
		verdict_t v;
		longint unsigned p, q, w, u1, u2, chk;
		bit ok;
		p = p_reg;
		q = q_reg;
		v = '{valid_res: 1'b0, no_inverse: 1'b1};
		if (p < 2 || q < 2)
			return v;
		w = inv_m(s, q, ok);
		if (!ok)
			return v;
		u1 = mul_m(z % q, w, q);
		u2 = mul_m(r % q, w, q);
		chk = mul_m(pow_m(g_reg, u1, p), pow_m(y_reg, u2, p), p) % q;
		v.no_inverse = 1'b0;
		v.valid_res = (chk == r);
		return v;
	endfunction

	// ------------------------------------------------------------------
	// idle lengths: mostly short, now and then long
	// ------------------------------------------------------------------
	function automatic int idle_len();
		int sel;
		if (no_idle)
			return 0;
		sel = $urandom_range(99);
		if (sel < 60)
			return 0;
		if (sel < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// ------------------------------------------------------------------
	// transaction tasks
	// ------------------------------------------------------------------
	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_P: p_reg = val;
			CFG_Q: q_reg = val;
			CFG_G: g_reg = val;
			CFG_Y: y_reg = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_domain(logic [31:0] p, logic [31:0] q, logic [31:0] g,
			logic [31:0] y);
		write_reg(CFG_P, p);
		write_reg(CFG_Q, q);
		write_reg(CFG_G, g);
		write_reg(CFG_Y, y);
	endtask

	// offer one signature; valid stays high across a zero-length gap
	task automatic send_sig(logic [63:0] z, logic [31:0] r, logic [31:0] s);
		int gap;
		in_valid <= 1'b1;
		digest <= z;
		sig_r <= r;
		sig_s <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		verdict_q.push_back(dsa_verdict(z, r, s));
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// lower valid and wait until every verdict has been returned
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// signature generation for a real subgroup
	// ------------------------------------------------------------------
	// picks g of order q from p, q and a fresh private key, then writes all four
	task automatic setup_group(longint unsigned p, longint unsigned q);
		longint unsigned h, g;
		h = 2;
		g = pow_m(h, (p - 1) / q, p);
		while (g == 1) begin
			h++;
			g = pow_m(h, (p - 1) / q, p);
		end
		priv_x = $urandom_range(1, 32'(q - 1));
		write_domain(32'(p), 32'(q), 32'(g), 32'(pow_m(g, priv_x, p)));
	endtask

	task automatic make_sig(logic [63:0] z, output logic [31:0] r, output logic [31:0] s);
		longint unsigned p, q, k, kinv, rr, ss;
		bit ok;
		p = p_reg;
		q = q_reg;
		do begin
			k = $urandom_range(1, 32'(q - 1));
			rr = pow_m(g_reg, k, p) % q;
			kinv = inv_m(k, q, ok);
			ss = mul_m(kinv, (z % q + mul_m(priv_x, rr, q)) % q, q);
		end while (rr == 0 || ss == 0);
		r = 32'(rr);
		s = 32'(ss);
	endtask

	// mostly genuine signatures, the rest tampered or plain noise
	task automatic send_mixed(int n);
		logic [63:0] z;
		logic [31:0] r, s;
		int sel;
		repeat (n) begin
			z = {$urandom, $urandom};
			make_sig(z, r, s);
			sel = $urandom_range(99);
			if (sel >= 90) begin
				r = $urandom;
				s = $urandom;
			end else if (sel >= 80) begin
				z[$urandom_range(63)] ^= 1'b1;
			end else if (sel >= 75) begin
				r = r + q_reg;
			end else if (sel >= 70) begin
				s = s + q_reg * $urandom_range(1, 3);
			end
			send_sig(z, r, s);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// registers still at reset: every check reports no inverse
	task automatic test_reset_params();
		send_sig('0, '0, '0);
		send_sig('1, '1, '1);
		send_sig(64'h5555_5555_AAAA_AAAA, 32'hAAAA_5555, 32'h5555_AAAA);
		wait_drain();
	endtask

	task automatic test_special_cases();
		logic [31:0] r, s;
		setup_group(607, 101);
		make_sig(64'd12345, r, s);
		send_sig(64'd12345, r, s);               // genuine
		send_sig(64'd12345 + 101, r, s);         // digest differs only above q
		send_sig(64'd12346, r, s);               // wrong digest
		send_sig(64'd12345, r + 101, s);         // r out of range
		send_sig(64'd12345, r, s + 101);         // s used mod q
		send_sig(64'd12345, r, 0);               // s zero
		send_sig(64'd12345, r, 101);             // s multiple of q
		send_sig('1, 0, 32'hFFFF_FFFF);
		wait_drain();
		// composite q: s sharing a factor has no inverse
		write_reg(CFG_Q, 100);
		send_sig(64'd77, 5, 10);
		send_sig(64'd77, 5, 7);
		wait_drain();
		// moduli below two
		write_reg(CFG_Q, 1);
		send_sig(64'd9, 1, 1);
		wait_drain();
		write_reg(CFG_Q, 101);
		write_reg(CFG_P, 1);
		send_sig(64'd9, 1, 1);
		wait_drain();
		write_reg(CFG_P, 0);
		send_sig(64'd9, 1, 1);
		wait_drain();
	endtask

	task automatic test_all_ones_params();
		int i;
		write_domain('1, '1, '1, '1);
		send_sig('1, '1, '1);
		send_sig('0, 1, 1);
		wait_drain();
		write_domain(32'hFFFF_FFFB, 32'hFFFF_FFFE, 32'h8000_0001, 32'hFFFF_FFF0);
		for (i = 0; i < 12; i++)
			send_sig({$urandom, $urandom}, $urandom, $urandom);
		wait_drain();
	endtask

	task automatic test_small_group();
		setup_group(607, 101);
		send_mixed(35);
		wait_drain();
	endtask

	// a burst with no idling on the input side, then one with idles
	task automatic test_mid_group();
		setup_group(32'd2147483647, 331);
		no_idle = 1'b1;
		send_mixed(15);
		no_idle = 1'b0;
		send_mixed(15);
		wait_drain();
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		setup_group(607, 101);
		hold_req = 20000;
		no_idle = 1'b1;
		send_mixed(4);
		no_idle = 1'b0;
		wait_drain();
	endtask

	// ------------------------------------------------------------------
	// receiver stall pattern
	// ------------------------------------------------------------------
	int stall_left;
	int hold_left;
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_left = idle_len();
			out_stall <= (stall_left > 0) && ($urandom_range(1) == 1);
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic got, logic want);
		errors++;
		$display("mismatch on %s: got %0b, expected %0b at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected result transaction", out_valid, 1'b0);
			end else begin
				want = verdict_q.pop_front();
				if (valid_res !== want.valid_res)
					report_mismatch("valid_res", valid_res, want.valid_res);
				if (no_inverse !== want.no_inverse)
					report_mismatch("no_inverse", no_inverse, want.no_inverse);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("dsa_signature_verifier_unit_tb failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_P;
		cfg_data = '0;
		in_valid = 1'b0;
		digest = '0;
		sig_r = '0;
		sig_s = '0;
		out_stall = 1'b0;
		p_reg = '0;
		q_reg = '0;
		g_reg = '0;
		y_reg = '0;
		errors = 0;
		cycles = 0;
		no_idle = 1'b0;
		hold_req = 0;
		hold_left = 0;
		stall_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_params();
		test_special_cases();
		test_all_ones_params();
		test_small_group();
		test_backpressure();
		test_mid_group();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("dsa_signature_verifier_unit_tb passed");
		end else begin
			$display("dsa_signature_verifier_unit_tb failed");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/dsv_pkg.sv
rtl/dsv_modmul.sv
rtl/dsv_divider.sv
rtl/dsa_signature_verifier_unit.sv
test/dsa_signature_verifier_unit_tb.sv
